### rtl/core/dpc_pkg.sv
package dpc_pkg;

    localparam int unsigned MaxPointsDefault = 256;
    localparam int unsigned CoordWidth       = 9;
    localparam int unsigned CountWidth       = 8;
    localparam int unsigned TotalWidth       = 15;

    localparam logic [CountWidth-1:0] CountMax = {CountWidth{1'b1}};
    localparam logic [TotalWidth-1:0] TotalMax = {TotalWidth{1'b1}};

    typedef struct packed {
        logic [CoordWidth-1:0] x_coord;
        logic [CoordWidth-1:0] y_coord;
        logic                  restart;
    } t_item;

    typedef struct packed {
        logic [CountWidth-1:0] dominated_count;
        logic [TotalWidth-1:0] running_total;
        logic                  store_full;
    } t_result;

    typedef struct packed {
        logic [CoordWidth-1:0] x_coord;
        logic [CoordWidth-1:0] y_coord;
    } t_point;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

endpackage

### rtl/core/dpc_point_store.sv
module dpc_point_store #(
    parameter int unsigned MAX_POINTS = dpc_pkg::MaxPointsDefault
) (
    input  logic                          i_clk,
    input  logic                          i_wr_en,
    input  logic [$clog2(MAX_POINTS)-1:0] i_wr_addr,
    input  dpc_pkg::t_point               i_wr_data,
    input  logic                          i_rd_en,
    input  logic [$clog2(MAX_POINTS)-1:0] i_rd_addr,
    output dpc_pkg::t_point               o_rd_data
);

    dpc_pkg::t_point r_mem [MAX_POINTS];
    dpc_pkg::t_point r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### rtl/core/dominance_pair_counter.sv
// Each point goes from start through S_SCAN, where one comparator walks the point
// memory through its single registered read port, one stored point per cycle, then
// S_FINISH, where the new point is written if there is room, and then o_done presents
// the result. busy stays high for the whole item and o_done pulses for exactly one
// cycle with the result, which the receiver cannot stall, so it must take every
// transfer. A new start may be issued in the cycle that o_done is high. Coordinates
// are compared as raw 9-bit values, the count saturates at 255 and the running
// total at 32767; once the memory holds MAX_POINTS points, further points are
// still counted but not kept.
module dominance_pair_counter #(
    parameter int unsigned MAX_POINTS = dpc_pkg::MaxPointsDefault
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  dpc_pkg::t_item   i_item,
    output logic             o_done,
    output dpc_pkg::t_result o_result
);

    localparam int unsigned AW = $clog2(MAX_POINTS);
    localparam int unsigned PW = $clog2(MAX_POINTS + 1);
    localparam logic [PW-1:0] PointsMax = PW'(MAX_POINTS);

    dpc_pkg::t_state r_state;
    dpc_pkg::t_state n_state;

    logic [dpc_pkg::CoordWidth-1:0] r_qx;
    logic [dpc_pkg::CoordWidth-1:0] r_qy;
    logic [PW-1:0]                  r_npts;
    logic [PW-1:0]                  r_idx;
    logic                           r_rd_vld;
    logic [dpc_pkg::CountWidth-1:0] r_hits;
    logic [dpc_pkg::TotalWidth-1:0] r_total;
    logic                           r_done;
    dpc_pkg::t_result               r_result;

    logic                           accept;
    logic                           rd_en;
    logic                           finish;
    logic                           hit;
    logic                           has_room;
    logic [dpc_pkg::TotalWidth:0]   total_sum;
    logic [dpc_pkg::TotalWidth-1:0] total_sat;
    dpc_pkg::t_point                wr_point;
    dpc_pkg::t_point                rd_point;

    assign busy   = (r_state != dpc_pkg::S_IDLE);
    assign accept = start && !busy;

    always_comb begin
        n_state = r_state;
        case (r_state)
            dpc_pkg::S_IDLE: begin
                if (start) begin
                    n_state = dpc_pkg::S_SCAN;
                end
            end
            dpc_pkg::S_SCAN: begin
                if ((r_idx == r_npts) && !r_rd_vld) begin
                    n_state = dpc_pkg::S_FINISH;
                end
            end
            dpc_pkg::S_FINISH: begin
                n_state = dpc_pkg::S_IDLE;
            end
            default: begin
                n_state = dpc_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        rd_en  = 1'b0;
        finish = 1'b0;
        case (r_state)
            dpc_pkg::S_SCAN: begin
                rd_en = (r_idx != r_npts);
            end
            dpc_pkg::S_FINISH: begin
                finish = 1'b1;
            end
            default: begin
                rd_en  = 1'b0;
                finish = 1'b0;
            end
        endcase
    end

    // The read data is registered, so r_rd_vld, the registered rd_en, marks a compare.
    assign hit = r_rd_vld && (rd_point.x_coord <= r_qx) && (rd_point.y_coord <= r_qy);

    assign has_room  = (r_npts < PointsMax);
    assign total_sum = {1'b0, r_total} + (dpc_pkg::TotalWidth + 1)'(r_hits);
    assign total_sat = total_sum[dpc_pkg::TotalWidth] ? dpc_pkg::TotalMax
                                                      : total_sum[dpc_pkg::TotalWidth-1:0];

    assign wr_point.x_coord = r_qx;
    assign wr_point.y_coord = r_qy;

    dpc_point_store #(
        .MAX_POINTS(MAX_POINTS)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (finish && has_room),
        .i_wr_addr (r_npts[AW-1:0]),
        .i_wr_data (wr_point),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_idx[AW-1:0]),
        .o_rd_data (rd_point)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= dpc_pkg::S_IDLE;
            r_npts   <= '0;
            r_total  <= '0;
            r_idx    <= '0;
            r_rd_vld <= 1'b0;
            r_hits   <= '0;
            r_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= rd_en;
            r_done   <= finish;
            if (accept) begin
                r_idx  <= '0;
                r_hits <= '0;
                if (i_item.restart) begin
                    r_npts  <= '0;
                    r_total <= '0;
                end
            end
            if (rd_en) begin
                r_idx <= r_idx + 1'b1;
            end
            if (hit && (r_hits != dpc_pkg::CountMax)) begin
                r_hits <= r_hits + 1'b1;
            end
            if (finish) begin
                r_total <= total_sat;
                if (has_room) begin
                    r_npts <= r_npts + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_qx <= i_item.x_coord;
            r_qy <= i_item.y_coord;
        end
        if (finish) begin
            r_result.dominated_count <= r_hits;
            r_result.running_total   <= total_sat;
            r_result.store_full      <= !has_room;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

### tb/tb_dominance_pair_counter.sv
module tb_dominance_pair_counter;

    localparam int unsigned StorePoints   = dpc_pkg::MaxPointsDefault;
    localparam int unsigned RandomItems   = 1400;
    localparam int unsigned SettleCycles  = 300;

    typedef struct {
        dpc_pkg::t_item   item;
        bit               typed;
        dpc_pkg::t_result want;
    } t_row;

    logic             i_clk   = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             start   = 1'b0;
    dpc_pkg::t_item   i_item  = '0;
    logic             busy;
    logic             o_done;
    dpc_pkg::t_result o_result;

    // Shadow copy of the point store and the running total.
    logic [dpc_pkg::CoordWidth-1:0] shadow_x [StorePoints];
    logic [dpc_pkg::CoordWidth-1:0] shadow_y [StorePoints];
    int unsigned                    shadow_count;
    int unsigned                    shadow_total;

    dpc_pkg::t_result pending_results [$];
    t_row             directed_rows [$];
    int unsigned      err_count;

    dominance_pair_counter DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_done   (o_done),
        .o_result (o_result)
    );

    always #10 i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        $display("mismatch: %s", msg);
        err_count++;
    endtask

    function automatic dpc_pkg::t_result predict_dominance(input dpc_pkg::t_item it);
        dpc_pkg::t_result res;
        int unsigned      hits;
        hits = 0;
        if (it.restart) begin
            shadow_count = 0;
            shadow_total = 0;
        end
        for (int k = 0; k < shadow_count; k++) begin
            if (shadow_x[k] <= it.x_coord && shadow_y[k] <= it.y_coord) hits++;
        end
        if (hits > dpc_pkg::CountMax) hits = dpc_pkg::CountMax;
        shadow_total += hits;
        if (shadow_total > dpc_pkg::TotalMax) shadow_total = dpc_pkg::TotalMax;
        res.dominated_count = hits[dpc_pkg::CountWidth-1:0];
        res.running_total   = shadow_total[dpc_pkg::TotalWidth-1:0];
        if (shadow_count < StorePoints) begin
            shadow_x[shadow_count] = it.x_coord;
            shadow_y[shadow_count] = it.y_coord;
            shadow_count++;
            res.store_full = 1'b0;
        end else begin
            res.store_full = 1'b1;
        end
        return res;
    endfunction

    function automatic dpc_pkg::t_item make_item(input int unsigned x, input int unsigned y,
                                                 input bit r);
        dpc_pkg::t_item it;
        it.x_coord = x[dpc_pkg::CoordWidth-1:0];
        it.y_coord = y[dpc_pkg::CoordWidth-1:0];
        it.restart = r;
        return it;
    endfunction

    task automatic add_row(input int unsigned x, input int unsigned y, input bit r,
                           input bit typed = 1'b0, input int unsigned cnt = 0,
                           input int unsigned tot = 0, input bit full = 1'b0);
        t_row row;
        row.item                 = make_item(x, y, r);
        row.typed                = typed;
        row.want.dominated_count = cnt[dpc_pkg::CountWidth-1:0];
        row.want.running_total   = tot[dpc_pkg::TotalWidth-1:0];
        row.want.store_full      = full;
        directed_rows.insert(directed_rows.size(), row);
    endtask

    // Holds the item on the ports until the block takes it. start stays high on
    // return so that a back-to-back transfer needs no second assignment.
    task automatic send_point(input dpc_pkg::t_item it, input bit typed,
                              input dpc_pkg::t_result want);
        dpc_pkg::t_result predicted;
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        predicted = predict_dominance(it);
        pending_results.insert(pending_results.size(), typed ? want : predicted);
    endtask

    task automatic pause_sender(input int unsigned n, input bit drain);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
        if (drain) begin
            while (pending_results.size() != 0) @(posedge i_clk);
        end
    endtask

    function automatic int unsigned pick_gap(input bit burst);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (burst || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(30, 120);
    endfunction

    function automatic int unsigned rand_coord(input int unsigned cmax);
        if ($urandom_range(0, 9) == 0) return $urandom_range(0, 511);
        return $urandom_range(1, cmax);
    endfunction

    always @(posedge i_clk) begin : check_results
        dpc_pkg::t_result want;
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result with nothing pending: count %0d total %0d",
                                          o_result.dominated_count, o_result.running_total));
            end else begin
                want = pending_results.pop_front();
                if (o_result.dominated_count !== want.dominated_count)
                    report_mismatch($sformatf("dominated_count got %0d want %0d",
                                              o_result.dominated_count, want.dominated_count));
                if (o_result.running_total !== want.running_total)
                    report_mismatch($sformatf("running_total got %0d want %0d",
                                              o_result.running_total, want.running_total));
                if (o_result.store_full !== want.store_full)
                    report_mismatch($sformatf("store_full got %0b want %0b",
                                              o_result.store_full, want.store_full));
            end
        end
    end

    initial begin : stimulus
        dpc_pkg::t_result none;
        dpc_pkg::t_item   it;
        int unsigned      random_sent;
        int unsigned      len;
        int unsigned      cmax;
        int unsigned      g;
        bit               fill;
        bit               keep;
        bit               burst;
        bit               r;

        none         = '0;
        err_count    = 0;
        shadow_count = 0;
        shadow_total = 0;
        random_sent  = 0;

        // Extremes of the coordinates, duplicates, zero and out-of-range values,
        // and restarts. Rows without a typed result go through the predictor.
        add_row(1,   1,   0, 1, 0, 0, 0);
        add_row(256, 256, 0, 1, 1, 1, 0);
        add_row(1,   1,   0, 1, 1, 2, 0);
        add_row(0,   0,   0, 1, 0, 2, 0);
        add_row(511, 511, 0, 1, 4, 6, 0);
        add_row(511, 0,   0, 1, 1, 7, 0);
        add_row(0,   511, 0, 1, 1, 8, 0);
        add_row(256, 1,   0);
        add_row(1,   256, 0);
        add_row(9'h155, 9'h0AA, 0);
        add_row(9'h0AA, 9'h155, 0);
        add_row(257, 257, 0);
        add_row(5,   5,   1, 1, 0, 0, 0);
        add_row(5,   5,   0, 1, 1, 1, 0);
        add_row(4,   5,   0, 1, 0, 1, 0);
        add_row(5,   4,   0, 1, 0, 1, 0);
        add_row(6,   6,   0, 1, 4, 5, 0);
        add_row(0,   0,   1, 1, 0, 0, 0);
        add_row(511, 511, 1, 1, 0, 0, 0);
        add_row(511, 511, 0, 1, 1, 1, 0);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[n]) begin
            send_point(directed_rows[n].item, directed_rows[n].typed, directed_rows[n].want);
            g = pick_gap(1'b0);
            if (g > 0) pause_sender(g, 1'b0);
        end
        pause_sender(1, 1'b1);

        // Ascending diagonal: each point dominates all earlier ones, so the store
        // fills, the count reaches its ceiling and the total saturates.
        for (int k = 0; k <= StorePoints; k++) begin
            it = make_item((k < StorePoints) ? k + 1 : StorePoints,
                           (k < StorePoints) ? k + 1 : StorePoints, k == 0);
            send_point(it, 1'b0, none);
            g = pick_gap(1'b0);
            if (g > 0) pause_sender(g, 1'b0);
        end
        send_point(make_item(511, 511, 0), 1'b0, none);
        pause_sender(1, 1'b1);

        // Random sessions: mostly short ones opened by a restart, now and then a
        // long one that runs the store full.
        while (random_sent < RandomItems) begin
            fill  = ($urandom_range(0, 99) < 2);
            len   = fill ? $urandom_range(StorePoints, StorePoints + 44) : $urandom_range(1, 24);
            case ($urandom_range(0, 2))
                0: cmax = 4;
                1: cmax = 16;
                default: cmax = 256;
            endcase
            keep  = ($urandom_range(0, 9) == 0);
            burst = ($urandom_range(0, 9) < 3);
            for (int i = 0; i < len; i++) begin
                r  = (i == 0) ? !keep : (!fill && $urandom_range(0, 19) == 0);
                it = make_item(rand_coord(cmax), rand_coord(cmax), r);
                send_point(it, 1'b0, none);
                random_sent++;
                g = pick_gap(burst);
                if (g > 0) pause_sender(g, 1'b0);
            end
            if ($urandom_range(0, 19) == 0) pause_sender(1, 1'b1);
        end

        pause_sender(1, 1'b0);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);

        if (err_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin : watchdog
        #60_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

### sim.f
rtl/core/dpc_pkg.sv
rtl/core/dpc_point_store.sv
rtl/core/dominance_pair_counter.sv
tb/tb_dominance_pair_counter.sv
